@@ rtl/core/lkvc_pkg.sv @@
// Shared constants and transaction types for the LRU key-value cache.
`timescale 1ns / 1ps

package lkvc_pkg;

   // Store geometry.
   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W   = $clog2(ENTRIES + 1);

   // Field widths fixed by the interface.
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   // Configuration register map.
   localparam int ADDR_W      = 3;
   localparam int DATA_W      = 32;
   localparam int REG_IDX_W   = 1;
   localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;
   localparam logic [CAP_W-1:0]     CAP_RESET    = CAP_W'(16);

   // Operation codes.
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // Registered request presented to the store.
   typedef struct packed {
      logic             valid;
      logic             opcode;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } lkvc_req_type;

   // Result of one transaction.
   typedef struct packed {
      logic             found;
      logic [VAL_W-1:0] read_value;
      logic             evicted;
      logic [KEY_W-1:0] evicted_key;
   } lkvc_rsp_type;

endpackage

@@ rtl/core/lkvc_csr.sv @@
// Configuration register block: holds the capacity register and derives the effective capacity.
`timescale 1ns / 1ps

module lkvc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lkvc_pkg::ADDR_W-1:0]   paddr,
   input  logic [lkvc_pkg::DATA_W-1:0]   pwdata,
   output logic [lkvc_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output logic [lkvc_pkg::OCC_W-1:0]    eff_cap
);
   import lkvc_pkg::*;

   logic [CAP_W-1:0]     capacity_ff;
   logic [CAP_W-1:0]     capacity_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   // Register index is the word address.
   assign reg_idx = paddr[ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite && pready;
   assign pready  = 1'b1;

   // Write decode; writes outside the map are dropped.
   always_comb begin
      capacity_in = capacity_ff;
      if (wr_en && (reg_idx == REG_CAPACITY)) begin
         capacity_in = pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // Read mux.
   always_comb begin
      prdata = '0;
      if (reg_idx == REG_CAPACITY) begin
         prdata = DATA_W'(capacity_ff);
      end
   end

   // Zero is treated as one; values above the store size saturate.
   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = OCC_W'(1);
      end else if (32'(capacity_ff) > ENTRIES) begin
         eff_cap = OCC_W'(ENTRIES);
      end else begin
         eff_cap = OCC_W'(capacity_ff);
      end
   end

endmodule

@@ rtl/core/lkvc_store.sv @@
// Fully associative entry store with parallel key match and recency rank update.
`timescale 1ns / 1ps

module lkvc_store (
   input  logic                        clock,
   input  logic                        reset,
   input  lkvc_pkg::lkvc_req_type      req,
   input  logic [lkvc_pkg::OCC_W-1:0]  eff_cap,
   output lkvc_pkg::lkvc_rsp_type      rsp
);
   import lkvc_pkg::*;

   logic [KEY_W-1:0] keys_ff   [ENTRIES];
   logic [VAL_W-1:0] values_ff [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [IDX_W-1:0] rank_ff [ENTRIES];
   logic [IDX_W-1:0] rank_in [ENTRIES];
   logic [OCC_W-1:0] occ_ff;
   logic [OCC_W-1:0] occ_in;

   logic [ENTRIES-1:0] hit_vec;
   logic [ENTRIES-1:0] victim_vec;
   logic               hit;
   logic [IDX_W-1:0]   hit_idx;
   logic [IDX_W-1:0]   victim_idx;
   logic [IDX_W-1:0]   free_idx;
   logic [IDX_W-1:0]   ins_idx;
   logic [IDX_W-1:0]   hit_rank;
   logic [IDX_W-1:0]   lru_rank;
   logic               full;
   logic               do_touch;
   logic               do_ins;
   logic               do_write;
   logic [IDX_W-1:0]   wr_idx;

   // Parallel compare against every entry; the oldest valid entry holds rank occupancy-1.
   assign lru_rank = IDX_W'(occ_ff - 1'b1);
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i]    = valid_ff[i] && (keys_ff[i] == req.key);
         victim_vec[i] = valid_ff[i] && (rank_ff[i] == lru_rank);
      end
   end

   // Priority encoders: the lowest matching slot wins.
   always_comb begin
      hit_idx    = '0;
      victim_idx = '0;
      free_idx   = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (victim_vec[i]) begin
            victim_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign hit      = |hit_vec;
   assign hit_rank = rank_ff[hit_idx];
   assign full     = occ_ff >= eff_cap;
   assign do_touch = req.valid && hit;
   assign do_ins   = req.valid && !hit && (req.opcode == OP_PUT);
   assign ins_idx  = full ? victim_idx : free_idx;

   // Payload write port: value update on a put hit, key and value on an insert.
   assign do_write = do_ins || (do_touch && (req.opcode == OP_PUT));
   assign wr_idx   = do_ins ? ins_idx : hit_idx;

   // Next recency ranks, valid bits and occupancy.
   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         if (do_touch) begin
            if (IDX_W'(i) == hit_idx) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end else if (do_ins) begin
            if (IDX_W'(i) == ins_idx) begin
               rank_in[i] = '0;
            end else if (valid_ff[i]) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
      end
      if (do_ins) begin
         valid_in[ins_idx] = 1'b1;
         if (!full) begin
            occ_in = occ_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // Entry payload storage, no reset.
   always_ff @(posedge clock) begin
      if (do_write) begin
         values_ff[wr_idx] <= req.value;
         if (do_ins) begin
            keys_ff[wr_idx] <= req.key;
         end
      end
   end

   // Transaction result.
   always_comb begin
      rsp.found       = hit;
      rsp.read_value  = '0;
      rsp.evicted     = do_ins && full;
      rsp.evicted_key = '0;
      if (hit && (req.opcode == OP_GET)) begin
         rsp.read_value = values_ff[hit_idx];
      end
      if (do_ins && full) begin
         rsp.evicted_key = keys_ff[victim_idx];
      end
   end

endmodule

@@ rtl/core/lru_key_value_cache.sv @@
// Top level of the LRU key-value cache: request and result registers around the store.
//
//   Channel   Direction  Handshake               Payload
//   request   in         start high, busy low    req_opcode, req_key, req_value
//   result    out        rsp_valid strobe        rsp_found, rsp_read_value,
//                                                rsp_evicted, rsp_evicted_key
//   config    in/out     APB psel/penable/pready capacity at byte address 0
//
// One transaction is accepted every cycle while busy is low; its result strobes
// once it has passed the request register and the result register around the
// combinational key match and rank update. The result lasts one cycle and the
// receiver cannot stall it. Synchronous reset empties the store and sets the
// capacity to 16; busy is high only during reset.
`timescale 1ns / 1ps

module lru_key_value_cache (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_opcode,
   input  logic signed [31:0]            req_key,
   input  logic signed [31:0]            req_value,
   output logic                          rsp_valid,
   output logic                          rsp_found,
   output logic signed [31:0]            rsp_read_value,
   output logic                          rsp_evicted,
   output logic signed [31:0]            rsp_evicted_key,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lkvc_pkg::ADDR_W-1:0]   paddr,
   input  logic [lkvc_pkg::DATA_W-1:0]   pwdata,
   output logic [lkvc_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   import lkvc_pkg::*;

   lkvc_req_type     req_ff;
   lkvc_req_type     req_in;
   lkvc_rsp_type     store_rsp;
   lkvc_rsp_type     rsp_ff;
   logic             rsp_valid_ff;
   logic [OCC_W-1:0] eff_cap;

   assign busy = reset;

   // Request register.
   always_comb begin
      req_in.valid  = start && !busy;
      req_in.opcode = req_opcode;
      req_in.key    = req_key;
      req_in.value  = req_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff.valid <= 1'b0;
      end else begin
         req_ff.valid <= req_in.valid;
      end
      req_ff.opcode <= req_in.opcode;
      req_ff.key    <= req_in.key;
      req_ff.value  <= req_in.value;
   end

   lkvc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .eff_cap (eff_cap)
   );

   lkvc_store u_store (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ff),
      .eff_cap (eff_cap),
      .rsp     (store_rsp)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_ff.valid;
      end
      rsp_ff <= store_rsp;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_ff.found;
   assign rsp_read_value  = rsp_ff.read_value;
   assign rsp_evicted     = rsp_ff.evicted;
   assign rsp_evicted_key = rsp_ff.evicted_key;

`ifndef ASSERT_OFF
   // Every accepted transaction produces exactly one result, after the request and result registers.
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("accepted transaction produced no result");

   // A result strobe always traces back to an accepted transaction.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_ff.valid))
      else $error("result strobe without a transaction");

   // An eviction only happens on a miss.
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_evicted && rsp_found))
      else $error("eviction reported on a hit");

   // A read value only comes from a hit.
   a_read_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_read_value != '0)) |-> rsp_found)
      else $error("read data returned on a miss");
`endif

endmodule

@@ verif/lkvc_tb_pkg.sv @@
// Scoreboard for the LRU key-value cache: predicts each result and checks it on arrival.
`timescale 1ns / 1ps

package lkvc_tb_pkg;

   import lkvc_pkg::*;

   class kv_cache_scoreboard;

      // Predicted contents of the store.
      logic [KEY_W-1:0] slot_key[ENTRIES];
      logic [VAL_W-1:0] slot_value[ENTRIES];
      bit               slot_valid[ENTRIES];
      int unsigned      slot_age[ENTRIES];
      int unsigned      occupancy;
      logic [CAP_W-1:0] capacity;

      // Results still owed by the block, oldest first.
      lkvc_rsp_type expected_results[$];
      int unsigned  mismatches;

      function new();
         foreach (slot_valid[i]) begin
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_valid[i] = 1'b0;
            slot_age[i]   = 0;
         end
         occupancy  = 0;
         capacity   = CAP_RESET;
         mismatches = 0;
      endfunction

      // Only the capacity register exists; writes to other indexes are dropped.
      function void write_register(int unsigned index, logic [DATA_W-1:0] data);
         if (index == int'(REG_CAPACITY)) begin
            capacity = data[CAP_W-1:0];
         end
      endfunction

      // Zero behaves as one and anything above the store size saturates.
      function int unsigned effective_capacity();
         if (capacity == 0) begin
            return 1;
         end
         if (int'(capacity) > ENTRIES) begin
            return ENTRIES;
         end
         return capacity;
      endfunction

      // Apply one accepted transaction to the predicted store and queue its result.
      function void note_access(logic opcode, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
         lkvc_rsp_type res;
         bit           hit;
         int           slot;
         int           victim;
         res  = '0;
         hit  = 1'b0;
         slot = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (!hit && slot_valid[i] && slot_key[i] == key) begin
               hit  = 1'b1;
               slot = i;
            end
         end
         if (hit) begin
            res.found = 1'b1;
            if (opcode == OP_GET) begin
               res.read_value = slot_value[slot];
            end else begin
               slot_value[slot] = value;
            end
            // Everything more recent than the hit entry ages by one.
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot_valid[i] && slot_age[i] < slot_age[slot]) begin
                  slot_age[i]++;
               end
            end
            slot_age[slot] = 0;
         end else if (opcode == OP_PUT) begin
            victim = -1;
            // At or above capacity, the oldest entry makes room for exactly one insert.
            if (occupancy >= effective_capacity()) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (slot_valid[i] && (victim < 0 || slot_age[i] > slot_age[victim])) begin
                     victim = i;
                  end
               end
               if (victim >= 0) begin
                  res.evicted       = 1'b1;
                  res.evicted_key   = slot_key[victim];
                  slot_valid[victim] = 1'b0;
                  occupancy--;
               end
            end
            if (victim < 0) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (victim < 0 && !slot_valid[i]) begin
                     victim = i;
                  end
               end
            end
            if (victim >= 0) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (slot_valid[i]) begin
                     slot_age[i]++;
                  end
               end
               slot_valid[victim] = 1'b1;
               slot_key[victim]   = key;
               slot_value[victim] = value;
               slot_age[victim]   = 0;
               occupancy++;
            end
         end
         expected_results.insert(expected_results.size(), res);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
         end
      endfunction

      // Compare one result strobe with the oldest prediction.
      function void check_result(logic found, logic [VAL_W-1:0] read_value,
                                 logic evicted, logic [KEY_W-1:0] evicted_key);
         lkvc_rsp_type want;
         if (expected_results.size() == 0) begin
            mismatches++;
            $error("result strobe with no transaction outstanding");
            return;
         end
         want = expected_results[0];
         expected_results.delete(0);
         compare_field("found", want.found, found);
         compare_field("read_value", want.read_value, read_value);
         compare_field("evicted", want.evicted, evicted);
         compare_field("evicted_key", want.evicted_key, evicted_key);
      endfunction

   endclass

endpackage

@@ verif/tb_lru_key_value_cache.sv @@
// Testbench top for the LRU key-value cache: directed and random gets and puts over many capacities.
`timescale 1ns / 1ps

module tb_lru_key_value_cache;

   import lkvc_pkg::*;
   import lkvc_tb_pkg::*;

   localparam int IDLE_LIMIT  = 500;
   localparam int PHASE_ITEMS = 120;

   logic              clock   = 1'b0;
   logic              reset   = 1'b1;
   logic              start   = 1'b0;
   logic              req_opcode = 1'b0;
   logic [31:0]       req_key    = '0;
   logic [31:0]       req_value  = '0;
   logic              psel    = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite  = 1'b0;
   logic [ADDR_W-1:0] paddr   = '0;
   logic [DATA_W-1:0] pwdata  = '0;

   logic              busy;
   logic              rsp_valid;
   logic              rsp_found;
   logic [31:0]       rsp_read_value;
   logic              rsp_evicted;
   logic [31:0]       rsp_evicted_key;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   kv_cache_scoreboard sb;
   int idle_cycles = 0;

   lru_key_value_cache uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_key         (req_key),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_read_value  (rsp_read_value),
      .rsp_evicted     (rsp_evicted),
      .rsp_evicted_key (rsp_evicted_key),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every result strobe is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_result(rsp_found, rsp_read_value, rsp_evicted, rsp_evicted_key);
      end
   end

   // Watchdog: end the run if no transaction moves for too long.
   always @(posedge clock) begin
      if ((!reset && start && busy === 1'b0) || rsp_valid === 1'b1) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Idle cycles with start low and junk on the request fields.
   task automatic drive_idle(int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         start      <= 1'b0;
         req_opcode <= 1'($urandom_range(0, 1));
         req_key    <= $urandom;
         req_value  <= $urandom;
      end
   endtask

   // Present one transaction and hold it until the block takes it.
   task automatic send_access(logic opcode, logic [31:0] key, logic [31:0] value);
      @(negedge clock);
      start      <= 1'b1;
      req_opcode <= opcode;
      req_key    <= key;
      req_value  <= value;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_access(opcode, key, value);
   endtask

   // Stop sending and let every outstanding result come back.
   task automatic drain_results();
      drive_idle(1);
      while (sb.expected_results.size() != 0) begin
         drive_idle(1);
      end
      drive_idle(4);
   endtask

   // APB write: setup cycle, then access cycle until pready.
   task automatic write_register(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      sb.write_register(addr >> 2, data);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Capacity write with random upper bits, which the register must ignore.
   task automatic set_capacity(logic [CAP_W-1:0] cap);
      write_register(ADDR_W'(REG_CAPACITY) << 2, ($urandom & ~32'h1F) | 32'(cap));
   endtask

   // Random traffic over a small key pool so that hits and evictions are frequent.
   task automatic random_phase(logic [CAP_W-1:0] cap, int unsigned items, bit no_gaps,
                               bit hold_mid);
      logic [31:0] pool[24];
      int unsigned pool_n;
      int unsigned roll;
      logic [31:0] key;
      drain_results();
      set_capacity(cap);
      pool_n = (cap == 0) ? 4 : ((int'(cap) > ENTRIES) ? ENTRIES + 3 : cap + 3);
      foreach (pool[i]) begin
         pool[i] = $urandom;
      end
      for (int unsigned n = 0; n < items; n++) begin
         if (hold_mid && n == items / 2) begin
            drain_results();
         end
         if (!no_gaps) begin
            roll = $urandom_range(0, 99);
            if (roll >= 95) begin
               drive_idle($urandom_range(8, 30));
            end else if (roll >= 70) begin
               drive_idle($urandom_range(1, 3));
            end
         end
         roll = $urandom_range(0, 9);
         key  = (roll == 0) ? $urandom : pool[$urandom_range(0, pool_n - 1)];
         send_access(1'($urandom_range(0, 1)), key, $urandom);
      end
   endtask

   initial begin
      sb = new();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Get on an empty store, then extreme keys and values.
      send_access(OP_GET, 32'h8000_0000, 32'h1111_1111);
      send_access(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_access(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_access(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_access(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_access(OP_GET, 32'h7FFF_FFFF, 32'h0);
      send_access(OP_GET, 32'h8000_0000, 32'h0);
      send_access(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_access(OP_GET, 32'h0000_0000, 32'h0);
      // Put hit overwrites the value and refreshes the entry.
      send_access(OP_PUT, 32'h7FFF_FFFF, 32'h5A5A_A5A5);
      send_access(OP_GET, 32'h7FFF_FFFF, 32'h0);

      // Capacity lowered below occupancy: one eviction per put miss.
      drain_results();
      set_capacity(CAP_W'(2));
      send_access(OP_PUT, 32'h1234_5678, 32'hCAFE_F00D);
      send_access(OP_PUT, 32'hDEAD_BEEF, 32'h0BAD_F00D);
      send_access(OP_GET, 32'h1234_5678, 32'h0);

      // Capacity zero behaves as one.
      drain_results();
      set_capacity(CAP_W'(0));
      send_access(OP_PUT, 32'h5555_AAAA, 32'hAAAA_5555);
      send_access(OP_GET, 32'h8000_0000, 32'h0);

      // A write outside the register map is ignored; capacity above the store saturates.
      drain_results();
      write_register(ADDR_W'(4), $urandom);
      set_capacity(CAP_W'(31));
      send_access(OP_PUT, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
      send_access(OP_GET, 32'h5555_AAAA, 32'h0);

      // Random traffic across a spread of capacities.
      random_phase(CAP_W'(16), PHASE_ITEMS, 1'b0, 1'b0);
      random_phase(CAP_W'(1), PHASE_ITEMS, 1'b0, 1'b0);
      random_phase(CAP_W'(5), PHASE_ITEMS, 1'b1, 1'b0);
      random_phase(CAP_W'(0), PHASE_ITEMS, 1'b0, 1'b1);
      random_phase(CAP_W'(31), PHASE_ITEMS, 1'b0, 1'b0);
      random_phase(CAP_W'(17), PHASE_ITEMS, 1'b1, 1'b0);
      random_phase(CAP_W'($urandom_range(2, 15)), PHASE_ITEMS, 1'b0, 1'b0);
      random_phase(CAP_W'(16), PHASE_ITEMS, 1'b0, 1'b1);
      random_phase(CAP_W'(2), PHASE_ITEMS, 1'b0, 1'b0);

      drain_results();
      if (sb.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_csr.sv
rtl/core/lkvc_store.sv
rtl/core/lru_key_value_cache.sv
verif/lkvc_tb_pkg.sv
verif/tb_lru_key_value_cache.sv
